>>> rtl/sobd_pkg.sv
// Shared types and constants for the square outline box detector.
// No dependencies; used by the edge evaluator and the top level.

package sobd_pkg;

	typedef enum logic [1:0] {
		REG_WIDTH     = 2'd0,
		REG_HEIGHT    = 2'd1,
		REG_BAND      = 2'd2,
		REG_THRESHOLD = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [7:0] top;
		logic [7:0] bottom;
		logic [7:0] left;
		logic [7:0] right;
	} hits_t;

	localparam logic [7:0] RESET_WIDTH     = 8'd64;
	localparam logic [7:0] RESET_HEIGHT    = 8'd64;
	localparam logic [7:0] RESET_BAND      = 8'd3;
	localparam logic [7:0] RESET_THRESHOLD = 8'd160;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	localparam logic [3:0] VISIBLE_SCALE = 4'd10;
	localparam logic [6:0] STRONG_SCALE  = 7'd100;
	localparam logic [6:0] STRONG_LENGTH = 7'd65;
	localparam logic [2:0] MIN_EDGES     = 3'd2;

endpackage

>>> rtl/sobd_eval.sv
// Edge evaluation: classifies the four band counts of a finished square.
// Depends on sobd_pkg.

module sobd_eval (
	input  sobd_pkg::hits_t hits,
	input  logic [7:0]      width,
	input  logic [7:0]      height,
	output logic [2:0]      edge_total,
	output logic            detected
);
	import sobd_pkg::*;

	logic [3:0][7:0] count;
	logic [3:0][7:0] length;
	logic [3:0]      visible;
	logic [3:0]      ratio_high;

	assign count  = {hits.top, hits.bottom, hits.left, hits.right};
	assign length = {width, width, height, height};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			visible[i]    = (12'(count[i]) * 12'(VISIBLE_SCALE)) > 12'(length[i]);
			ratio_high[i] = (15'(count[i]) * 15'(STRONG_SCALE)) >
				(15'(length[i]) * 15'(STRONG_LENGTH));
		end
	end

	assign edge_total = 3'(visible[0]) + 3'(visible[1]) + 3'(visible[2]) + 3'(visible[3]);
	assign detected   = (edge_total >= MIN_EDGES) || (|ratio_high);

endmodule

>>> rtl/square_outline_box_detector_unit.sv
// Top level of the square outline box detector: pixel pipeline and result register.
// Depends on sobd_pkg and sobd_eval.

// The block takes one pixel word per clock and never stalls its input for its
// own work; a pixel is classified as white in the input register, band marks,
// row flags and counters are updated in the next stage, and the word for a
// finished square goes through the stage-two register to the output register.
// The column marks live in flip-flops and are cleared at the start and end of
// every square, so back-to-back squares need no gap. Input stall rises only
// when the words of two finished squares are waiting, one held by a stalled
// output and one behind it, and a further square ends.

module square_outline_box_detector_unit #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  sobd_pkg::reg_index_t cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          blue,
	input  logic [7:0]          green,
	input  logic [7:0]          red,
	input  logic                square_start,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          top_hits,
	output logic [7:0]          bottom_hits,
	output logic [7:0]          left_hits,
	output logic [7:0]          right_hits,
	output logic [2:0]          edge_total,
	output logic                detected
);
	import sobd_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CW    = ((POS_W > 8) ? POS_W : 8) + 1;
	localparam int W_CAP = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
	localparam int H_CAP = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;

	function automatic logic [7:0] bump(input logic [7:0] c, input logic hit);
		logic [7:0] r;
		r = c;
		if (hit && (c != COUNT_MAX)) begin
			r = c + 8'd1;
		end
		return r;
	endfunction

	logic [7:0] width_q, height_q, band_q, threshold_q;
	logic [7:0] w, h, t, wh_min;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= RESET_WIDTH;
			height_q    <= RESET_HEIGHT;
			band_q      <= RESET_BAND;
			threshold_q <= RESET_THRESHOLD;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WIDTH:     width_q     <= cfg_data;
				REG_HEIGHT:    height_q    <= cfg_data;
				REG_BAND:      band_q      <= cfg_data;
				REG_THRESHOLD: threshold_q <= cfg_data;
				default:       width_q     <= width_q;
			endcase
		end
	end

	always_comb begin
		w = (width_q == 8'd0) ? 8'd1 : ((width_q > 8'(W_CAP)) ? 8'(W_CAP) : width_q);
		h = (height_q == 8'd0) ? 8'd1 : ((height_q > 8'(H_CAP)) ? 8'(H_CAP) : height_q);
		wh_min = (w < h) ? w : h;
		t = (band_q == 8'd0) ? 8'd1 : ((band_q > wh_min) ? wh_min : band_q);
	end

	logic s1_valid, white_s1, start_s1;
	logic s1_ready, s1_fire;
	logic s2_valid, s2_ready;
	logic s3_ready;
	hits_t hits_s2;

	logic [COL_W-1:0]     col_q, col_e;
	logic [ROW_W-1:0]     row_q, row_e;
	logic [MAX_WIDTH-1:0] top_marks_q, bottom_marks_q;
	logic [MAX_WIDTH-1:0] top_base, bottom_base;
	logic [7:0]           top_q, bottom_q, left_q, right_q;
	logic [7:0]           top_e, bottom_e, left_e, right_e;
	logic                 left_flag_q, right_flag_q, left_flag_e, right_flag_e;
	logic                 top_mark_e, bottom_mark_e;
	logic                 top_hit, bottom_hit, left_hit, right_hit;
	logic                 row_end, square_end;
	hits_t                hits_next;

	assign s3_ready = !out_valid || !out_stall;
	assign s2_ready = !s2_valid || s3_ready;
	assign s1_fire  = s1_valid && (!square_end || s2_ready);
	assign s1_ready = !s1_valid || s1_fire;
	assign in_stall = !s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s1_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_ready) begin
			white_s1 <= (blue >= threshold_q) && (green >= threshold_q) && (red >= threshold_q);
			start_s1 <= square_start;
		end
	end

	always_comb begin
		col_e         = start_s1 ? '0 : col_q;
		row_e         = start_s1 ? '0 : row_q;
		top_e         = start_s1 ? 8'd0 : top_q;
		bottom_e      = start_s1 ? 8'd0 : bottom_q;
		left_e        = start_s1 ? 8'd0 : left_q;
		right_e       = start_s1 ? 8'd0 : right_q;
		left_flag_e   = !start_s1 && left_flag_q;
		right_flag_e  = !start_s1 && right_flag_q;
		top_base      = start_s1 ? '0 : top_marks_q;
		bottom_base   = start_s1 ? '0 : bottom_marks_q;
		top_mark_e    = top_base[col_e];
		bottom_mark_e = bottom_base[col_e];

		top_hit    = white_s1 && (CW'(row_e) < CW'(t)) && !top_mark_e;
		bottom_hit = white_s1 && (CW'(row_e) >= CW'(h - t)) && !bottom_mark_e;
		left_hit   = white_s1 && (CW'(col_e) < CW'(t)) && !left_flag_e;
		right_hit  = white_s1 && (CW'(col_e) >= CW'(w - t)) && !right_flag_e;

		row_end    = !((CW'(col_e) + CW'(1)) < CW'(w));
		square_end = row_end && !((CW'(row_e) + CW'(1)) < CW'(h));

		hits_next.top    = bump(top_e, top_hit);
		hits_next.bottom = bump(bottom_e, bottom_hit);
		hits_next.left   = bump(left_e, left_hit);
		hits_next.right  = bump(right_e, right_hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q          <= '0;
			row_q          <= '0;
			top_marks_q    <= '0;
			bottom_marks_q <= '0;
			top_q          <= 8'd0;
			bottom_q       <= 8'd0;
			left_q         <= 8'd0;
			right_q        <= 8'd0;
			left_flag_q    <= 1'b0;
			right_flag_q   <= 1'b0;
		end else if (s1_fire) begin
			if (square_end) begin
				col_q          <= '0;
				row_q          <= '0;
				top_marks_q    <= '0;
				bottom_marks_q <= '0;
				top_q          <= 8'd0;
				bottom_q       <= 8'd0;
				left_q         <= 8'd0;
				right_q        <= 8'd0;
				left_flag_q    <= 1'b0;
				right_flag_q   <= 1'b0;
			end else begin
				col_q          <= row_end ? '0 : col_e + COL_W'(1);
				row_q          <= row_end ? row_e + ROW_W'(1) : row_e;
				top_marks_q    <= top_base | (MAX_WIDTH'(top_hit) << col_e);
				bottom_marks_q <= bottom_base | (MAX_WIDTH'(bottom_hit) << col_e);
				top_q          <= hits_next.top;
				bottom_q       <= hits_next.bottom;
				left_q         <= hits_next.left;
				right_q        <= hits_next.right;
				left_flag_q    <= !row_end && (left_flag_e || left_hit);
				right_flag_q   <= !row_end && (right_flag_e || right_hit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_ready) begin
			s2_valid <= s1_fire && square_end;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s1_fire && square_end) begin
			hits_s2 <= hits_next;
		end
	end

	logic [2:0] edges_calc;
	logic       detected_calc;

	sobd_eval u_eval (
		.hits       (hits_s2),
		.width      (w),
		.height     (h),
		.edge_total (edges_calc),
		.detected   (detected_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s3_ready) begin
			out_valid <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && s2_valid) begin
			top_hits    <= hits_s2.top;
			bottom_hits <= hits_s2.bottom;
			left_hits   <= hits_s2.left;
			right_hits  <= hits_s2.right;
			edge_total  <= edges_calc;
			detected    <= detected_calc;
		end
	end

endmodule
